@@ rtl/nsr_pkg.sv @@
// Package with shared widths, types and register indexes of the nearest site ranking core.
`timescale 1ns / 1ps

package nsr_pkg;

    localparam int MAX_SITES_DEF = 32;
    localparam int ID_W          = 16;
    localparam int COORD_W       = 16;
    localparam int DIST_W        = 33;
    localparam int SQ_W          = 32;
    localparam int CFG_ADDR_W    = 1;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] sq_dist;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CALC  = 7'b0000010,
        ST_SEEK  = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_PUT   = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_DRAIN = 7'b1000000
    } state_t;

    function automatic logic ranks_before(entry_t a, entry_t b);
        return (a.sq_dist < b.sq_dist) || ((a.sq_dist == b.sq_dist) && (a.id < b.id));
    endfunction

endpackage

@@ rtl/nearest_site_ranking_core.sv @@
// Top level of the nearest site ranking core: configuration, insertion sequencer and output.
// An item runs through calc and seek, and then also walks the store unless the store is empty or full.
// The walk does at most one RAM read and one write per cycle; the next item is accepted after busy falls.
// An item marked final then emits one result per cycle, fill results in all, once it is stored or dropped.
// The receiver cannot stall; results are strobed by result_valid for one cycle each.
// Reset clears the origin, fill count and overflow flag; store contents need no clearing.
`timescale 1ns / 1ps

module nearest_site_ranking_core #(
    parameter int MAX_SITES = nsr_pkg::MAX_SITES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [nsr_pkg::ID_W-1:0]             site_id,
    input  logic signed [nsr_pkg::COORD_W-1:0]   site_x,
    input  logic signed [nsr_pkg::COORD_W-1:0]   site_y,
    input  logic                                 final_site,
    input  logic                                 cfg_we,
    input  logic [nsr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [nsr_pkg::COORD_W-1:0]          cfg_wdata,
    output logic                                 result_valid,
    output logic [nsr_pkg::ID_W-1:0]             ranked_id,
    output logic [nsr_pkg::DIST_W-1:0]           dist_squared,
    output logic                                 end_of_rank,
    output logic                                 sites_dropped
);

    localparam int AW = $clog2(MAX_SITES);
    localparam int CW = $clog2(MAX_SITES + 1);

    nsr_pkg::state_t                  state_reg;
    nsr_pkg::state_t                  state_next;
    nsr_pkg::state_t                  done_state;
    logic signed [nsr_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [nsr_pkg::COORD_W-1:0] origin_y_reg;
    logic [CW-1:0]                    fill_reg;
    logic [CW-1:0]                    fill_next;
    logic                             ovf_reg;
    logic                             ovf_next;
    logic [AW-1:0]                    pos_reg;
    logic [AW-1:0]                    pos_next;
    logic [AW-1:0]                    emit_cnt_reg;
    logic [AW-1:0]                    emit_cnt_next;
    logic                             out_v_reg;
    logic                             out_v_next;
    logic                             out_last_reg;
    logic                             out_last_next;
    logic [nsr_pkg::ID_W-1:0]         id_reg;
    logic                             final_reg;
    logic                             accept;
    logic [nsr_pkg::DIST_W-1:0]       sq_dist;
    logic                             dist_valid;
    nsr_pkg::entry_t                  new_entry;
    nsr_pkg::entry_t                  rd_entry;
    logic [nsr_pkg::ENTRY_W-1:0]      rdata;
    logic                             we;
    logic [AW-1:0]                    waddr;
    nsr_pkg::entry_t                  wdata;
    logic                             re;
    logic [AW-1:0]                    raddr;

    assign accept = start && (state_reg == nsr_pkg::ST_IDLE);
    assign busy   = (state_reg != nsr_pkg::ST_IDLE);

    nsr_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .site_x     (site_x),
        .site_y     (site_y),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .sq_dist    (sq_dist),
        .dist_valid (dist_valid)
    );

    nsr_ram #(
        .WIDTH (nsr_pkg::ENTRY_W),
        .DEPTH (MAX_SITES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        new_entry.id      = id_reg;
        new_entry.sq_dist = sq_dist;
        rd_entry          = nsr_pkg::entry_t'(rdata);
        done_state        = final_reg ? nsr_pkg::ST_EMIT : nsr_pkg::ST_IDLE;

        state_next    = state_reg;
        fill_next     = fill_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        emit_cnt_next = emit_cnt_reg;
        out_v_next    = 1'b0;
        out_last_next = 1'b0;
        we            = 1'b0;
        waddr         = pos_reg;
        wdata         = new_entry;
        re            = 1'b0;
        raddr         = '0;

        case (state_reg)
            nsr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = nsr_pkg::ST_CALC;
                end
            end
            nsr_pkg::ST_CALC:
            begin
                if (dist_valid)
                begin
                    state_next = nsr_pkg::ST_SEEK;
                end
            end
            nsr_pkg::ST_SEEK:
            begin
                if (fill_reg == CW'(MAX_SITES))
                begin
                    ovf_next   = 1'b1;
                    state_next = done_state;
                end
                else if (fill_reg == '0)
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    fill_next  = fill_reg + CW'(1);
                    state_next = done_state;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = fill_reg[AW-1:0] - AW'(1);
                    pos_next   = fill_reg[AW-1:0];
                    state_next = nsr_pkg::ST_WALK;
                end
            end
            nsr_pkg::ST_WALK:
            begin
                we = 1'b1;
                if (nsr_pkg::ranks_before(new_entry, rd_entry))
                begin
                    wdata = rd_entry;
                    if (pos_reg == AW'(1))
                    begin
                        pos_next   = '0;
                        state_next = nsr_pkg::ST_PUT;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = pos_reg - AW'(1) - AW'(1);
                        pos_next = pos_reg - AW'(1);
                    end
                end
                else
                begin
                    fill_next  = fill_reg + CW'(1);
                    state_next = done_state;
                end
            end
            nsr_pkg::ST_PUT:
            begin
                we         = 1'b1;
                fill_next  = fill_reg + CW'(1);
                state_next = done_state;
            end
            nsr_pkg::ST_EMIT:
            begin
                re         = 1'b1;
                raddr      = emit_cnt_reg;
                out_v_next = 1'b1;
                if ((CW'(emit_cnt_reg) + CW'(1)) == fill_reg)
                begin
                    out_last_next = 1'b1;
                    emit_cnt_next = '0;
                    state_next    = nsr_pkg::ST_DRAIN;
                end
                else
                begin
                    emit_cnt_next = emit_cnt_reg + AW'(1);
                end
            end
            nsr_pkg::ST_DRAIN:
            begin
                fill_next  = '0;
                ovf_next   = 1'b0;
                state_next = nsr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = nsr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nsr_pkg::ST_IDLE;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            pos_reg      <= '0;
            emit_cnt_reg <= '0;
            out_v_reg    <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            pos_reg      <= pos_next;
            emit_cnt_reg <= emit_cnt_next;
            out_v_reg    <= out_v_next;
            out_last_reg <= out_last_next;
            if (cfg_we && (cfg_addr == nsr_pkg::CFG_ORIGIN_X))
            begin
                origin_x_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == nsr_pkg::CFG_ORIGIN_Y))
            begin
                origin_y_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= site_id;
            final_reg <= final_site;
        end
    end

    assign result_valid  = out_v_reg;
    assign ranked_id     = rd_entry.id;
    assign dist_squared  = rd_entry.sq_dist;
    assign end_of_rank   = out_last_reg;
    assign sites_dropped = ovf_reg;

endmodule

@@ rtl/nsr_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module nsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/nsr_dist.sv @@
// Two-stage pipeline that computes the exact squared distance of a site to the origin.
`timescale 1ns / 1ps

module nsr_dist (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [nsr_pkg::COORD_W-1:0] site_x,
    input  logic signed [nsr_pkg::COORD_W-1:0] site_y,
    input  logic signed [nsr_pkg::COORD_W-1:0] origin_x,
    input  logic signed [nsr_pkg::COORD_W-1:0] origin_y,
    output logic [nsr_pkg::DIST_W-1:0]        sq_dist,
    output logic                              dist_valid
);

    logic signed [nsr_pkg::COORD_W:0]     dx;
    logic signed [nsr_pkg::COORD_W:0]     dy;
    logic signed [2*nsr_pkg::COORD_W+1:0] px;
    logic signed [2*nsr_pkg::COORD_W+1:0] py;
    logic [nsr_pkg::SQ_W-1:0]             sq_x_reg;
    logic [nsr_pkg::SQ_W-1:0]             sq_y_reg;
    logic                                 v1_reg;
    logic [nsr_pkg::DIST_W-1:0]           dist_reg;
    logic [nsr_pkg::DIST_W-1:0]           dist_next;
    logic                                 v2_reg;

    always_comb
    begin
        dx = {site_x[nsr_pkg::COORD_W-1], site_x} - {origin_x[nsr_pkg::COORD_W-1], origin_x};
        dy = {site_y[nsr_pkg::COORD_W-1], site_y} - {origin_y[nsr_pkg::COORD_W-1], origin_y};
        px = dx * dx;
        py = dy * dy;
        dist_next = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sq_x_reg <= px[nsr_pkg::SQ_W-1:0];
            sq_y_reg <= py[nsr_pkg::SQ_W-1:0];
        end
        if (v1_reg)
        begin
            dist_reg <= dist_next;
        end
    end

    assign sq_dist    = dist_reg;
    assign dist_valid = v2_reg;

endmodule
